// ===== rtl/core/rpmr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmr_pkg: shared definitions for the region point move/rotate block
// Register indexes, CORDIC constants, arctangent table and sequencer states.
// ----------------------------------------------------------------------------
package rpmr_pkg;

   // default widths
   localparam int COORD_WIDTH_DEF = 32;
   localparam int ANGLE_WIDTH_DEF = 16;

   // configuration register indexes
   localparam int CSR_IDX_WIDTH = 4;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_PIVOT_X = 4'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_PIVOT_Y = 4'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_PIVOT_Z = 4'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_AXIS_X  = 4'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_AXIS_Y  = 4'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_AXIS_Z  = 4'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_ANGLE   = 4'd6;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_MODE    = 4'd7;

   // axis z reset value, 1.0 in Q2.30
   localparam logic signed [31:0] AXIS_ONE = 32'sd1073741824;

   // cordic constants
   localparam int CORDIC_WIDTH = 34;
   localparam int CORDIC_STEPS = 30;
   localparam int CNT_WIDTH    = 5;
   localparam logic [CNT_WIDTH-1:0] CNT_LAST = 5'd29;
   localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_START = 34'sd652032874;

   // sincos sequencer states
   typedef enum logic [1:0] {
      CS_LOAD,
      CS_RUN,
      CS_IDLE
   } cordic_state_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic signed [CORDIC_WIDTH-1:0] atan_turn(input logic [CNT_WIDTH-1:0] i);
      logic signed [CORDIC_WIDTH-1:0] v;
      case (i)
         5'd0:  v = 34'sd536870912;
         5'd1:  v = 34'sd316933406;
         5'd2:  v = 34'sd167458907;
         5'd3:  v = 34'sd85004756;
         5'd4:  v = 34'sd42667331;
         5'd5:  v = 34'sd21354465;
         5'd6:  v = 34'sd10679838;
         5'd7:  v = 34'sd5340245;
         5'd8:  v = 34'sd2670163;
         5'd9:  v = 34'sd1335087;
         5'd10: v = 34'sd667544;
         5'd11: v = 34'sd333772;
         5'd12: v = 34'sd166886;
         5'd13: v = 34'sd83443;
         5'd14: v = 34'sd41722;
         5'd15: v = 34'sd20861;
         5'd16: v = 34'sd10430;
         5'd17: v = 34'sd5215;
         5'd18: v = 34'sd2608;
         5'd19: v = 34'sd1304;
         5'd20: v = 34'sd652;
         5'd21: v = 34'sd326;
         5'd22: v = 34'sd163;
         5'd23: v = 34'sd81;
         5'd24: v = 34'sd41;
         5'd25: v = 34'sd20;
         5'd26: v = 34'sd10;
         5'd27: v = 34'sd5;
         5'd28: v = 34'sd3;
         5'd29: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/region_point_move_rotate.sv =====
`timescale 1ns / 1ps
// throughput: one transaction per cycle while rsp_tready allows and no sincos run is active, 15-stage datapath pipeline
// sine/cosine come from a two-lane iterative cordic that runs after reset
// and after each angle write; req_tready stays low during that run
// reset: synchronous, active high; clears valid bits, registers to reset values
// ----------------------------------------------------------------------------
// region_point_move_rotate
// Moves a Q16.16 point between region space and moved space: offset plus
// Rodrigues rotation about an axis through a pivot, each enabled by a mode bit, pipelined.
// ----------------------------------------------------------------------------
module region_point_move_rotate #(
   parameter int COORD_WIDTH = rpmr_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH = rpmr_pkg::ANGLE_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   // request channel
   input  logic req_tvalid,
   output logic req_tready,
   // pos_x, pos_y, pos_z, shift_x, shift_y, shift_z (lowest bits first)
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // cmd: 0 inverse, 1 forward
   input  logic req_tuser,
   // response channel
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_x, out_y, out_z (lowest bits first)
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // configuration write channel
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [rpmr_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] csr_data
);

   localparam int W   = COORD_WIDTH;
   localparam int RDW = ((3*COORD_WIDTH+7)/8)*8;
   localparam int MW  = (COORD_WIDTH + 14 > 34) ? COORD_WIDTH + 14 : 34;
   localparam int HW  = MW - 30;
   localparam int PW  = HW + 32;
   localparam int PW1 = PW + 1;
   localparam int CW  = rpmr_pkg::CORDIC_WIDTH;
   localparam int NS  = 15;

   // rounded Q2.30 product split at bit 30: high part times factor
   function automatic logic signed [PW-1:0] mq_hi(input logic signed [MW-1:0] v,
                                                   input logic signed [31:0] f);
      logic signed [HW-1:0] h;
      h = v[MW-1:30];
      return PW'(h) * PW'(f);
   endfunction

   // low part times factor plus the rounding half
   function automatic logic signed [63:0] mq_lo(input logic signed [MW-1:0] v,
                                                input logic signed [31:0] f);
      logic signed [30:0] l;
      l = {1'b0, v[29:0]};
      return 64'(l) * 64'(f) + 64'sd536870912;
   endfunction

   // recombine the two partial products
   function automatic logic signed [MW-1:0] mq_fin(input logic signed [PW-1:0] hp,
                                                   input logic signed [63:0] lp);
      logic signed [PW1-1:0] sum;
      logic signed [63:0]    lsh;
      lsh = lp >>> 30;
      sum = PW1'(hp) + PW1'(lsh);
      return sum[MW-1:0];
   endfunction

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic signed [W-1:0]             pivot_ff [3];
   logic signed [31:0]              axis_ff  [3];
   logic [ANGLE_WIDTH-1:0]          angle_ff;
   logic [1:0]                      mode_ff;
   logic                            csr_wr;
   logic                            angle_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign angle_wr  = csr_wr && (csr_index == rpmr_pkg::REG_ANGLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_ff[0] <= '0;
         pivot_ff[1] <= '0;
         pivot_ff[2] <= '0;
         axis_ff[0]  <= '0;
         axis_ff[1]  <= '0;
         axis_ff[2]  <= rpmr_pkg::AXIS_ONE;
         angle_ff    <= '0;
         mode_ff     <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            rpmr_pkg::REG_PIVOT_X: pivot_ff[0] <= csr_data[W-1:0];
            rpmr_pkg::REG_PIVOT_Y: pivot_ff[1] <= csr_data[W-1:0];
            rpmr_pkg::REG_PIVOT_Z: pivot_ff[2] <= csr_data[W-1:0];
            rpmr_pkg::REG_AXIS_X:  axis_ff[0]  <= csr_data[31:0];
            rpmr_pkg::REG_AXIS_Y:  axis_ff[1]  <= csr_data[31:0];
            rpmr_pkg::REG_AXIS_Z:  axis_ff[2]  <= csr_data[31:0];
            rpmr_pkg::REG_ANGLE:   angle_ff    <= csr_data[ANGLE_WIDTH-1:0];
            rpmr_pkg::REG_MODE:    mode_ff     <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // sincos sequencer: lane 0 for +angle (forward), lane 1 for -angle
   // ------------------------------------------------------------------
   rpmr_pkg::cordic_state_type cs_ff, cs_in;
   logic [rpmr_pkg::CNT_WIDTH-1:0] cnt_ff;
   logic                           cs_busy, cs_load, cs_step;
   logic signed [CW-1:0]           cx_ff [2];
   logic signed [CW-1:0]           cy_ff [2];
   logic signed [CW-1:0]           cz_ff [2];
   logic [1:0]                     ck_ff [2];
   logic signed [31:0]             sin_q [2];
   logic signed [31:0]             cos_q [2];
   logic [31:0]                    phase [2];
   logic [31:0]                    ph_adj [2];

   // next state
   always_comb begin
      cs_in = cs_ff;
      case (cs_ff)
         rpmr_pkg::CS_LOAD: cs_in = rpmr_pkg::CS_RUN;
         rpmr_pkg::CS_RUN:  if (cnt_ff == rpmr_pkg::CNT_LAST) cs_in = rpmr_pkg::CS_IDLE;
         rpmr_pkg::CS_IDLE: if (angle_wr) cs_in = rpmr_pkg::CS_LOAD;
         default:           cs_in = rpmr_pkg::CS_LOAD;
      endcase
      // a new angle restarts the run from any state
      if (angle_wr) cs_in = rpmr_pkg::CS_LOAD;
   end

   // state outputs
   always_comb begin
      cs_busy = 1'b1;
      cs_load = 1'b0;
      cs_step = 1'b0;
      case (cs_ff)
         rpmr_pkg::CS_LOAD: cs_load = 1'b1;
         rpmr_pkg::CS_RUN:  cs_step = 1'b1;
         rpmr_pkg::CS_IDLE: cs_busy = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff  <= rpmr_pkg::CS_LOAD;
         cnt_ff <= '0;
      end else begin
         cs_ff <= cs_in;
         if (cs_load)      cnt_ff <= '0;
         else if (cs_step) cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // phase of each lane, reduced by the nearest quarter turn
   always_comb begin
      phase[0] = 32'(angle_ff) << (32 - ANGLE_WIDTH);
      phase[1] = 32'd0 - phase[0];
      for (int l = 0; l < 2; l++) begin
         ph_adj[l] = phase[l] + 32'h2000_0000;
      end
   end

   // rotation-mode iterations
   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         if (cs_load) begin
            ck_ff[l] <= ph_adj[l][31:30];
            cx_ff[l] <= rpmr_pkg::CORDIC_START;
            cy_ff[l] <= '0;
            cz_ff[l] <= CW'($signed(phase[l] - {ph_adj[l][31:30], 30'd0}));
         end else if (cs_step) begin
            if (!cz_ff[l][CW-1]) begin
               cx_ff[l] <= cx_ff[l] - (cy_ff[l] >>> cnt_ff);
               cy_ff[l] <= cy_ff[l] + (cx_ff[l] >>> cnt_ff);
               cz_ff[l] <= cz_ff[l] - rpmr_pkg::atan_turn(cnt_ff);
            end else begin
               cx_ff[l] <= cx_ff[l] + (cy_ff[l] >>> cnt_ff);
               cy_ff[l] <= cy_ff[l] - (cx_ff[l] >>> cnt_ff);
               cz_ff[l] <= cz_ff[l] + rpmr_pkg::atan_turn(cnt_ff);
            end
         end
      end
   end

   // quadrant fold back
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         case (ck_ff[l])
            2'd0: begin
               cos_q[l] = cx_ff[l][31:0];
               sin_q[l] = cy_ff[l][31:0];
            end
            2'd1: begin
               cos_q[l] = 32'd0 - cy_ff[l][31:0];
               sin_q[l] = cx_ff[l][31:0];
            end
            2'd2: begin
               cos_q[l] = 32'd0 - cx_ff[l][31:0];
               sin_q[l] = 32'd0 - cy_ff[l][31:0];
            end
            default: begin
               cos_q[l] = cy_ff[l][31:0];
               sin_q[l] = 32'd0 - cx_ff[l][31:0];
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // pipeline control: per-stage enable, valid bits travel with data
   // ------------------------------------------------------------------
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] en;
   logic          req_acc;

   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || rsp_tready;
      for (int k = NS-2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[0] && !cs_busy;
   assign req_acc    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= req_acc;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // datapath registers
   // ------------------------------------------------------------------
   logic                fwd_ff [NS];
   logic signed [W-1:0] q_ff   [NS][3];
   logic signed [W-1:0] sh_ff  [NS][3];
   logic signed [MW-1:0] d_ff  [NS][3];
   logic signed [MW-1:0] cp_ff [NS][3];
   logic signed [MW-1:0] ac_ff [NS][3];
   logic signed [PW-1:0] hd_ff [3];
   logic signed [63:0]   ld_ff [3];
   logic signed [MW-1:0] m_ff  [3];
   logic signed [MW-1:0] dot_ff;
   logic signed [PW-1:0] hc_ff [3];
   logic signed [63:0]   lc_ff [3];
   logic signed [MW-1:0] a_ff  [3];
   logic signed [PW-1:0] ha_ff [9];
   logic signed [63:0]   la_ff [9];
   logic signed [MW-1:0] t_ff  [9];
   logic signed [MW-1:0] b_ff  [3];
   logic signed [PW-1:0] hb_ff [3];
   logic signed [63:0]   lb_ff [3];
   logic signed [MW-1:0] bs_ff [3];
   logic signed [W-1:0]  x_ff  [3];
   logic signed [W-1:0]  o_ff  [3];

   // operand routing for the cross product and cosine terms
   logic signed [MW-1:0] va [9];
   logic signed [31:0]   fa [9];
   logic signed [31:0]   c_use, s_use;
   logic signed [W-1:0]  p_in  [3];
   logic signed [W-1:0]  sh_in [3];
   logic signed [MW-1:0] sum13 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_in[i]  = req_tdata[i*W +: W];
         sh_in[i] = req_tdata[(i+3)*W +: W];
      end
      c_use = fwd_ff[7] ? cos_q[0] : cos_q[1];
      s_use = fwd_ff[10] ? sin_q[0] : sin_q[1];
      va[0] = a_ff[2]; fa[0] = axis_ff[1];
      va[1] = a_ff[1]; fa[1] = axis_ff[2];
      va[2] = a_ff[0]; fa[2] = axis_ff[2];
      va[3] = a_ff[2]; fa[3] = axis_ff[0];
      va[4] = a_ff[1]; fa[4] = axis_ff[0];
      va[5] = a_ff[0]; fa[5] = axis_ff[1];
      va[6] = a_ff[0]; fa[6] = c_use;
      va[7] = a_ff[1]; fa[7] = c_use;
      va[8] = a_ff[2]; fa[8] = c_use;
      for (int i = 0; i < 3; i++) begin
         sum13[i] = MW'(pivot_ff[i]) + cp_ff[12][i] + ac_ff[12][i] + bs_ff[i];
      end
   end

   // side fields that ride along the pipeline
   always_ff @(posedge clock) begin
      if (en[0]) begin
         fwd_ff[0] <= req_tuser;
         for (int i = 0; i < 3; i++) begin
            sh_ff[0][i] <= sh_in[i];
            // inverse mode removes the offset first
            q_ff[0][i]  <= (!req_tuser && mode_ff[0]) ? (p_in[i] - sh_in[i]) : p_in[i];
         end
      end
      for (int k = 1; k < NS; k++) begin
         if (en[k]) begin
            fwd_ff[k] <= fwd_ff[k-1];
            q_ff[k]   <= q_ff[k-1];
            sh_ff[k]  <= sh_ff[k-1];
         end
      end
      // offset from pivot, carried to the subtraction of the projection
      if (en[1]) begin
         for (int i = 0; i < 3; i++) d_ff[1][i] <= MW'(q_ff[0][i]) - MW'(pivot_ff[i]);
      end
      for (int k = 2; k < NS; k++) begin
         if (en[k]) d_ff[k] <= d_ff[k-1];
      end
      // projection term carried to the final sum
      if (en[6]) begin
         for (int i = 0; i < 3; i++) cp_ff[6][i] <= mq_fin(hc_ff[i], lc_ff[i]);
      end
      for (int k = 7; k < NS; k++) begin
         if (en[k]) cp_ff[k] <= cp_ff[k-1];
      end
      // cosine term carried to the final sum
      if (en[9]) begin
         for (int i = 0; i < 3; i++) ac_ff[9][i] <= mq_fin(ha_ff[i+6], la_ff[i+6]);
      end
      for (int k = 10; k < NS; k++) begin
         if (en[k]) ac_ff[k] <= ac_ff[k-1];
      end
   end

   // arithmetic stages
   always_ff @(posedge clock) begin
      // d . axis partial products
      if (en[2]) begin
         for (int i = 0; i < 3; i++) begin
            hd_ff[i] <= mq_hi(d_ff[1][i], axis_ff[i]);
            ld_ff[i] <= mq_lo(d_ff[1][i], axis_ff[i]);
         end
      end
      if (en[3]) begin
         for (int i = 0; i < 3; i++) m_ff[i] <= mq_fin(hd_ff[i], ld_ff[i]);
      end
      if (en[4]) dot_ff <= m_ff[0] + m_ff[1] + m_ff[2];
      // projection onto the axis
      if (en[5]) begin
         for (int i = 0; i < 3; i++) begin
            hc_ff[i] <= mq_hi(dot_ff, axis_ff[i]);
            lc_ff[i] <= mq_lo(dot_ff, axis_ff[i]);
         end
      end
      if (en[7]) begin
         for (int i = 0; i < 3; i++) a_ff[i] <= d_ff[6][i] - cp_ff[6][i];
      end
      // cross product and cosine partial products
      if (en[8]) begin
         for (int j = 0; j < 9; j++) begin
            ha_ff[j] <= mq_hi(va[j], fa[j]);
            la_ff[j] <= mq_lo(va[j], fa[j]);
         end
      end
      if (en[9]) begin
         for (int j = 0; j < 6; j++) t_ff[j] <= mq_fin(ha_ff[j], la_ff[j]);
      end
      if (en[10]) begin
         b_ff[0] <= t_ff[0] - t_ff[1];
         b_ff[1] <= t_ff[2] - t_ff[3];
         b_ff[2] <= t_ff[4] - t_ff[5];
      end
      // sine term
      if (en[11]) begin
         for (int i = 0; i < 3; i++) begin
            hb_ff[i] <= mq_hi(b_ff[i], s_use);
            lb_ff[i] <= mq_lo(b_ff[i], s_use);
         end
      end
      if (en[12]) begin
         for (int i = 0; i < 3; i++) bs_ff[i] <= mq_fin(hb_ff[i], lb_ff[i]);
      end
      // rotated point or bypass
      if (en[13]) begin
         for (int i = 0; i < 3; i++) begin
            x_ff[i] <= mode_ff[1] ? sum13[i][W-1:0] : q_ff[12][i];
         end
      end
      // forward mode adds the offset last
      if (en[14]) begin
         for (int i = 0; i < 3; i++) begin
            o_ff[i] <= (fwd_ff[13] && mode_ff[0]) ? (x_ff[i] + sh_ff[13][i]) : x_ff[i];
         end
      end
   end

   // response
   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tdata  = RDW'({o_ff[2], o_ff[1], o_ff[0]});

endmodule

// ===== rtl/core/rpmr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpmr_checker
// Port-level checks for region_point_move_rotate, attached by bind.
// ----------------------------------------------------------------------------
module rpmr_checker #(
   parameter int COORD_WIDTH = rpmr_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH = rpmr_pkg::ANGLE_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [((6*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input logic req_tuser,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((3*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input logic csr_valid,
   input logic csr_ready,
   input logic [rpmr_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] csr_data
);

   // reset empties the pipeline and starts the sincos run
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("response valid or request ready right after reset");

   // a stalled response holds its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // an angle write blocks requests while sine and cosine are recomputed
   a_angle_busy: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && csr_index == rpmr_pkg::REG_ANGLE
         |=> !req_tready ##1 !req_tready)
      else $error("request accepted during sincos recompute");

endmodule

bind region_point_move_rotate rpmr_checker #(
   .COORD_WIDTH(COORD_WIDTH),
   .ANGLE_WIDTH(ANGLE_WIDTH)
) u_rpmr_checker (.*);
